### hdl/circular_deque_defines.svh
// ---------------------------------------------------------------------------
// circular_deque assertion macros
// Shared property shorthands for the deque's checks.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cdq_pkg.sv
// ---------------------------------------------------------------------------
// cdq_pkg
// Types and codes shared by the deque top level and its storage cells.
// ---------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int VAL_W  = 32;  // value field width on both channels
  localparam int WIDE_W = 64;  // widest supported stored element

  typedef enum logic [2:0] {
    CMD_PUSH_REAR  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_DISPLAY    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // what a cell loads next cycle
  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_LOAD  = 3'd1,
    CELL_LEFT  = 3'd2,
    CELL_RIGHT = 3'd3,
    CELL_HEAD  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic signed [VAL_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
  } out_item_t;

endpackage

`default_nettype wire

### hdl/cdq_cell.sv
// ---------------------------------------------------------------------------
// cdq_cell
// One element of the deque chain: holds a value, or takes a new one from
// the push data, either neighbour, or the front cell.
// ---------------------------------------------------------------------------
`default_nettype none

module cdq_cell
  import cdq_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [DATA_WIDTH-1:0] load_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] head_data,
  output logic [DATA_WIDTH-1:0] q
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    case (op)
      CELL_HOLD:  data_nxt = data_r;
      CELL_LOAD:  data_nxt = load_data;
      CELL_LEFT:  data_nxt = left_data;
      CELL_RIGHT: data_nxt = right_data;
      CELL_HEAD:  data_nxt = head_data;
      default:    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

`default_nettype wire

### hdl/circular_deque.sv
// ---------------------------------------------------------------------------
// circular_deque
// Fixed-depth double-ended queue built as a row of storage cells.
// ---------------------------------------------------------------------------
//
//   channel | ports                      | carries
//   --------+----------------------------+------------------------------
//   input   | in_valid/in_ready/in_data  | cmd, push_value
//   result  | out_valid/out_ready/out_data | status, out_value, last
//
// Push and pop each complete with one transfer; the result lands in the output
// register at the accepting edge.
// Display of n held elements is one transfer, then one rotation step of the cell
// chain per element. A refused display gives its result at the transfer alone.
// Reset (rst_n, synchronous) empties the deque; cell contents are not reset.
// A stalled result register blocks new input transfers and display steps.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

`include "circular_deque_defines.svh"

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SHOW = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;     // held elements; front is cell 0
  logic [CNT_W-1:0]  disp_left_r, disp_left_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic [DATA_WIDTH-1:0] push_data;
  logic [DATA_WIDTH-1:0] rear_data;
  logic [CNT_W-1:0]      count_m1;
  logic [IDX_W-1:0]      rear_idx;
  logic [WIDE_W-1:0]     push_wide;

  logic acc, out_can, is_empty, is_full, emit;
  logic act_push_rear, act_push_front, act_pop_front, act_rotate;
  status_t               em_status;
  logic [DATA_WIDTH-1:0] em_data;
  logic                  em_last;

  function automatic logic [VAL_W-1:0] to_field(input logic [DATA_WIDTH-1:0] d);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(d);  // stored value zero-extended, then cut to field
    return w[VAL_W-1:0];
  endfunction

  // --- handshake -----------------------------------------------------------
  assign out_can  = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_can;
  assign acc      = in_valid && in_ready;

  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign count_m1 = count_r - CNT_W'(1);
  assign rear_idx = count_m1[IDX_W-1:0];
  assign rear_data = cell_q[rear_idx];

  assign push_wide = {{(WIDE_W - VAL_W){1'b0}}, in_data.push_value};
  assign push_data = push_wide[DATA_WIDTH-1:0];

  // --- command decode and display sequencing -------------------------------
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    disp_left_nxt  = disp_left_r;
    act_push_rear  = 1'b0;
    act_push_front = 1'b0;
    act_pop_front  = 1'b0;
    act_rotate     = 1'b0;
    emit           = 1'b0;
    em_status      = STAT_OK;
    em_data        = '0;
    em_last        = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_data.cmd)
            CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
              emit = 1'b1;
              if (is_full) begin
                em_status = STAT_FULL;
              end else begin
                act_push_rear  = (in_data.cmd == CMD_PUSH_REAR);
                act_push_front = (in_data.cmd == CMD_PUSH_FRONT);
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
              emit = 1'b1;
              if (is_empty) begin
                em_status = STAT_EMPTY;
              end else begin
                em_data       = (in_data.cmd == CMD_POP_FRONT) ? cell_q[0] : rear_data;
                act_pop_front = (in_data.cmd == CMD_POP_FRONT);
                count_nxt     = count_m1;
              end
            end
            CMD_DISPLAY: begin
              if (is_empty) begin
                emit      = 1'b1;
                em_status = STAT_EMPTY;
              end else begin
                state_nxt     = ST_SHOW;
                disp_left_nxt = count_r;
              end
            end
            default: ;  // unused codes: no result
          endcase
        end
      end
      ST_SHOW: begin
        // front cell goes out, the held region rotates by one
        if (out_can) begin
          emit          = 1'b1;
          em_data       = cell_q[0];
          em_last       = (disp_left_r == CNT_W'(1));
          act_rotate    = 1'b1;
          disp_left_nxt = disp_left_r - CNT_W'(1);
          if (em_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --- cell chain ----------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] POS = CNT_W'(i);
    cell_op_t              op_c;
    logic [DATA_WIDTH-1:0] left_d, right_d;

    if (i == 0) begin : g_first
      assign left_d = push_data;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[0];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    always_comb begin
      op_c = CELL_HOLD;
      if (act_push_rear && POS == count_r) begin
        op_c = CELL_LOAD;
      end else if (act_push_front) begin
        if (i == 0) begin
          op_c = CELL_LOAD;
        end else if (POS <= count_r) begin
          op_c = CELL_LEFT;
        end
      end else if ((act_pop_front || act_rotate) && POS < count_m1) begin
        op_c = CELL_RIGHT;
      end else if (act_rotate && POS == count_m1) begin
        op_c = CELL_HEAD;
      end
    end

    cdq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .op         (op_c),
      .load_data  (push_data),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_q[0]),
      .q          (cell_q[i])
    );
  end

  // --- result register -----------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.status    = em_status;
      out_item_nxt.out_value = to_field(em_data);
      out_item_nxt.last      = em_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      disp_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      disp_left_r <= disp_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // --- checks --------------------------------------------------------------
  `CDQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "deque count above depth")
  `CDQ_ASSERT_NOW(a_show_blocks, state_r == ST_SHOW, !in_ready, "input taken during display")
  `CDQ_ASSERT_NEXT(a_show_entry,
    acc && in_data.cmd == CMD_DISPLAY && !is_empty,
    state_r == ST_SHOW, "display did not start")
  `CDQ_ASSERT_NEXT(a_full_refuse,
    acc && (in_data.cmd == CMD_PUSH_REAR || in_data.cmd == CMD_PUSH_FRONT) && is_full,
    out_valid_r && out_data.status == STAT_FULL && count_r == CNT_W'(DEPTH),
    "full push not refused")

endmodule

`default_nettype wire
